### src/vat_pkg.sv
// Shared types, register codes and constants of the vertex affine transform.
// Holds the payload structs, the arctangent table and the saturation helper.
// Used by vat_trig, vat_xform and vertex_affine_transform; depends on nothing.
package vat_pkg;

    localparam int COORD_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int TRIG_W     = 32;
    localparam int TRIG_FRAC  = 30;
    localparam int WIDE_W     = 66;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT      = 2'd2;

    // Operation codes.
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_ROTATE    = 2'd1;
    localparam logic [1:0] OP_SCALE     = 2'd2;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // CORDIC start value (inverse gain) and degree-to-radian factor.
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam int                       DEG_RAD_W       = 27;
    localparam logic [DEG_RAD_W-1:0]     DEG_TO_RAD_Q32  = 27'd74961321;

    // Arctangent of 2^-i with 30 fraction bits, rounded.
    localparam int ATAN_LEN   = 32;
    localparam int ATAN_IDX_W = 5;
    localparam logic [TRIG_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd1
    };

    // One vertex on the input channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
        logic                      last_vertex;
    } t_vertex;

    // One transformed vertex on the output channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      out_last;
    } t_result;

    // Cached sine and cosine (30 fraction bits) with their ready flag.
    typedef struct packed {
        logic                     ready;
        logic signed [TRIG_W-1:0] sine;
        logic signed [TRIG_W-1:0] cosine;
    } t_trig;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/vat_trig.sv
// Sine and cosine unit: reduces the angle modulo 360 degrees with a reciprocal
// multiply and one correction, converts it to radians and runs an iterative CORDIC.
// Depends on vat_pkg.
module vat_trig #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [vat_pkg::COORD_W-1:0] i_amount,
    output vat_pkg::t_trig                    o_trig
);

    // Angle constants in the amount's fixed-point format.
    localparam longint FULL    = longint'(360) <<< FRACTION_BITS;
    localparam longint HALF    = longint'(180) <<< FRACTION_BITS;
    localparam longint QUARTER = longint'(90) <<< FRACTION_BITS;
    // Multiple of a full turn that makes every amount non-negative.
    localparam longint BIAS    = (((longint'(1) <<< 31) + FULL - 1) / FULL) * FULL;

    // A full turn is an odd count times 2^LOW_W, so the reduction divides the
    // upper bits by that odd count and leaves the lower bits untouched.
    localparam int     REM_W    = 35;
    localparam int     LOW_W    = FRACTION_BITS + 3;
    localparam int     TURN_ODD = int'(FULL >>> LOW_W);
    localparam int     T_W      = REM_W - LOW_W;
    localparam int     RECIP_SH = T_W + 1;
    localparam longint RECIP    = (longint'(1) <<< RECIP_SH) / TURN_ODD;
    localparam int     RECIP_W  = $clog2(RECIP + 1);
    localparam int     PQ_W     = T_W + RECIP_W;
    localparam int     MAG_W    = $clog2(QUARTER + 1);
    localparam int     PROD_W   = MAG_W + vat_pkg::DEG_RAD_W;
    localparam int     CORD_W   = 34;

    localparam logic [REM_W-1:0]        FULL_V   = REM_W'(FULL);
    localparam logic [REM_W-1:0]        HALF_V   = REM_W'(HALF);
    localparam logic [T_W:0]            TURN_V   = (T_W + 1)'(TURN_ODD);
    localparam logic [PQ_W-1:0]         RECIP_V  = PQ_W'(RECIP);
    localparam logic signed [REM_W:0]   BIAS_S   = (REM_W + 1)'(BIAS);
    localparam logic signed [REM_W:0]   FULL_S   = (REM_W + 1)'(FULL);
    localparam logic signed [REM_W:0]   HALF_S   = (REM_W + 1)'(HALF);
    localparam logic signed [REM_W:0]   QTR_S    = (REM_W + 1)'(QUARTER);
    localparam logic [PROD_W-1:0]       RAD_HALF = PROD_W'(longint'(1) <<< (FRACTION_BITS + 1));
    localparam logic [vat_pkg::ATAN_IDX_W-1:0] LAST_STEP =
        vat_pkg::ATAN_IDX_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_QUOT,
        S_REDUCE,
        S_FOLD,
        S_RADIAN,
        S_ROTATE,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [REM_W-1:0]                r_rem;
    logic [T_W-1:0]                  r_quot;
    logic                            r_flip;
    logic                            r_neg;
    logic [MAG_W-1:0]                r_mag;
    logic signed [CORD_W-1:0]        r_x;
    logic signed [CORD_W-1:0]        r_y;
    logic signed [CORD_W-1:0]        r_z;
    logic [vat_pkg::ATAN_IDX_W-1:0]  r_step;
    logic signed [vat_pkg::TRIG_W-1:0] r_sine;
    logic signed [vat_pkg::TRIG_W-1:0] r_cosine;

    logic signed [REM_W:0]           w_load;
    logic [T_W-1:0]                  w_coarse;
    logic [PQ_W-1:0]                 w_qprod;
    logic [T_W:0]                    w_qmul;
    logic [T_W:0]                    w_part;
    logic [T_W:0]                    w_part_fix;
    logic signed [REM_W:0]           w_wrap;
    logic signed [REM_W:0]           w_fold;
    logic                            w_flip;
    logic signed [REM_W:0]           w_abs;
    logic [PROD_W-1:0]               w_prod;
    logic signed [CORD_W-1:0]        w_rad;
    logic signed [CORD_W-1:0]        w_xs;
    logic signed [CORD_W-1:0]        w_ys;
    logic signed [CORD_W-1:0]        w_atan;
    logic signed [CORD_W-1:0]        n_x;
    logic signed [CORD_W-1:0]        n_y;
    logic signed [CORD_W-1:0]        n_z;
    logic signed [CORD_W-1:0]        w_cos_out;
    logic signed [CORD_W-1:0]        w_sin_out;

    // Biased amount for the modulo reduction.
    assign w_load = (REM_W + 1)'(i_amount) + BIAS_S;

    // Whole turns by a reciprocal multiply; the estimate is exact or one low,
    // so one compare and subtract finishes the remainder.
    assign w_coarse   = r_rem[REM_W-1:LOW_W];
    assign w_qprod    = PQ_W'(w_coarse) * RECIP_V;
    assign w_qmul     = (T_W + 1)'(r_quot) * TURN_V;
    assign w_part     = {1'b0, w_coarse} - w_qmul;
    assign w_part_fix = (w_part >= TURN_V) ? (w_part - TURN_V) : w_part;

    // Fold the remainder into (-180, 180] and then into [-90, 90].
    always_comb begin
        w_wrap = (r_rem > HALF_V) ? $signed({1'b0, r_rem}) - FULL_S
                                  : $signed({1'b0, r_rem});
        w_flip = 1'b0;
        w_fold = w_wrap;
        if (w_wrap > QTR_S) begin
            w_fold = w_wrap - HALF_S;
            w_flip = 1'b1;
        end else if (w_wrap < -QTR_S) begin
            w_fold = w_wrap + HALF_S;
            w_flip = 1'b1;
        end
        w_abs = (w_fold < 0) ? -w_fold : w_fold;
    end

    // Degrees to radians with 30 fraction bits, rounded half up.
    assign w_prod = PROD_W'(r_mag) * PROD_W'(vat_pkg::DEG_TO_RAD_Q32) + RAD_HALF;
    assign w_rad  = CORD_W'(w_prod >> (FRACTION_BITS + 2));

    // One CORDIC rotation step.
    always_comb begin
        w_xs   = r_x >>> r_step;
        w_ys   = r_y >>> r_step;
        w_atan = CORD_W'(vat_pkg::ATAN_Q30[r_step]);
        if (!r_z[CORD_W-1]) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_atan;
        end
        w_cos_out = r_flip ? -n_x : n_x;
        w_sin_out = r_flip ? -n_y : n_y;
    end

    // Sequencer: load, quotient estimate, remainder, fold, radian conversion, CORDIC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_sine   <= '0;
            r_cosine <= '0;
        end else if (i_start) begin
            r_state <= S_LOAD;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    r_rem   <= w_load[REM_W-1:0];
                    r_state <= S_QUOT;
                end
                S_QUOT: begin
                    r_quot  <= T_W'(w_qprod >> RECIP_SH);
                    r_state <= S_REDUCE;
                end
                S_REDUCE: begin
                    r_rem   <= {w_part_fix[T_W-1:0], r_rem[LOW_W-1:0]};
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_flip  <= w_flip;
                    r_neg   <= (w_fold < 0);
                    r_mag   <= w_abs[MAG_W-1:0];
                    r_state <= S_RADIAN;
                end
                S_RADIAN: begin
                    r_x     <= CORD_W'(vat_pkg::CORDIC_GAIN_Q30);
                    r_y     <= '0;
                    r_z     <= r_neg ? -w_rad : w_rad;
                    r_step  <= '0;
                    r_state <= S_ROTATE;
                end
                S_ROTATE: begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_z    <= n_z;
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_cosine <= w_cos_out[vat_pkg::TRIG_W-1:0];
                        r_sine   <= w_sin_out[vat_pkg::TRIG_W-1:0];
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_DONE;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_trig.ready  = (r_state == S_DONE);
    assign o_trig.sine   = r_sine;
    assign o_trig.cosine = r_cosine;

    // The reduction must leave a value below one full turn.
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (r_rem < FULL_V))
        else $error("angle remainder not reduced below a full turn");

    // Results are published only at the end of the CORDIC run.
    a_done_after_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_trig.ready)) |-> ($past(r_state == S_ROTATE) && $past(r_step == LAST_STEP)))
        else $error("trig ready raised outside the last CORDIC step");

endmodule

### src/vat_xform.sv
// Transform datapath: translate, rotate or scale one vertex with saturation.
// Four shared 32x32 multipliers serve both rotation and scaling.
// Depends on vat_pkg.
module vat_xform #(
    parameter int FRACTION_BITS = 16
) (
    input  vat_pkg::t_vertex                   i_vertex,
    input  logic [1:0]                         i_operation,
    input  logic [1:0]                         i_axis_select,
    input  logic signed [vat_pkg::COORD_W-1:0] i_amount,
    input  vat_pkg::t_trig                     i_trig,
    output vat_pkg::t_result                   o_result
);

    localparam int W  = vat_pkg::COORD_W;
    localparam int WW = vat_pkg::WIDE_W;
    localparam logic signed [WW-1:0] ROT_HALF   = WW'(longint'(1) <<< (vat_pkg::TRIG_FRAC - 1));
    localparam logic signed [WW-1:0] SCALE_HALF = WW'(longint'(1) <<< (FRACTION_BITS - 1));

    logic signed [W-1:0]    w_a;
    logic signed [W-1:0]    w_b;
    logic signed [W-1:0]    w_ma [4];
    logic signed [W-1:0]    w_mb [4];
    logic signed [2*W-1:0]  w_p  [4];
    logic signed [WW-1:0]   w_na_sum;
    logic signed [WW-1:0]   w_nb_sum;
    logic signed [W-1:0]    w_na;
    logic signed [W-1:0]    w_nb;
    logic signed [W-1:0]    w_scaled [3];
    logic signed [WW-1:0]   w_sc_sum [3];
    logic signed [WW-1:0]   w_amt_w;
    logic signed [W-1:0]    w_x;
    logic signed [W-1:0]    w_y;
    logic signed [W-1:0]    w_z;

    // Pick the coordinate pair that turns about the selected axis.
    always_comb begin
        case (i_axis_select)
            vat_pkg::AXIS_X: begin
                w_a = i_vertex.in_y;
                w_b = i_vertex.in_z;
            end
            vat_pkg::AXIS_Y: begin
                w_a = i_vertex.in_x;
                w_b = i_vertex.in_z;
            end
            default: begin
                w_a = i_vertex.in_x;
                w_b = i_vertex.in_y;
            end
        endcase
    end

    // Multiplier operands: three coordinates by the factor when scaling,
    // otherwise the pair by cosine and sine.
    always_comb begin
        if (i_operation == vat_pkg::OP_SCALE) begin
            w_ma[0] = i_vertex.in_x;
            w_ma[1] = i_vertex.in_y;
            w_ma[2] = i_vertex.in_z;
            w_ma[3] = '0;
            w_mb[0] = i_amount;
            w_mb[1] = i_amount;
            w_mb[2] = i_amount;
            w_mb[3] = '0;
        end else begin
            w_ma[0] = w_a;
            w_mb[0] = i_trig.cosine;
            w_ma[1] = w_b;
            w_mb[1] = i_trig.sine;
            w_ma[2] = w_b;
            w_mb[2] = i_trig.cosine;
            w_ma[3] = w_a;
            w_mb[3] = i_trig.sine;
        end
        for (int j = 0; j < 4; j++) begin
            w_p[j] = w_ma[j] * w_mb[j];
        end
    end

    // Rotation sums, rounded half up at 30 fraction bits.
    always_comb begin
        w_na_sum = WW'(w_p[0]) + WW'(w_p[1]) + ROT_HALF;
        w_nb_sum = WW'(w_p[2]) - WW'(w_p[3]) + ROT_HALF;
        w_na     = vat_pkg::sat32(w_na_sum >>> vat_pkg::TRIG_FRAC);
        w_nb     = vat_pkg::sat32(w_nb_sum >>> vat_pkg::TRIG_FRAC);
        for (int j = 0; j < 3; j++) begin
            w_sc_sum[j] = WW'(w_p[j]) + SCALE_HALF;
            w_scaled[j] = vat_pkg::sat32(w_sc_sum[j] >>> FRACTION_BITS);
        end
    end

    // Apply the configured operation.
    always_comb begin
        w_amt_w = WW'(i_amount);
        w_x     = i_vertex.in_x;
        w_y     = i_vertex.in_y;
        w_z     = i_vertex.in_z;
        case (i_operation)
            vat_pkg::OP_TRANSLATE: begin
                case (i_axis_select)
                    vat_pkg::AXIS_X: w_x = vat_pkg::sat32(WW'(i_vertex.in_x) + w_amt_w);
                    vat_pkg::AXIS_Y: w_y = vat_pkg::sat32(WW'(i_vertex.in_y) + w_amt_w);
                    vat_pkg::AXIS_Z: w_z = vat_pkg::sat32(WW'(i_vertex.in_z) + w_amt_w);
                    default: ;
                endcase
            end
            vat_pkg::OP_ROTATE: begin
                case (i_axis_select)
                    vat_pkg::AXIS_X: begin
                        w_y = w_na;
                        w_z = w_nb;
                    end
                    vat_pkg::AXIS_Y: begin
                        w_x = w_na;
                        w_z = w_nb;
                    end
                    vat_pkg::AXIS_Z: begin
                        w_x = w_na;
                        w_y = w_nb;
                    end
                    default: ;
                endcase
            end
            vat_pkg::OP_SCALE: begin
                // A factor of zero or below leaves the vertex as it is.
                if (i_amount > 32'sd0) begin
                    w_x = w_scaled[0];
                    w_y = w_scaled[1];
                    w_z = w_scaled[2];
                end
            end
            default: ;
        endcase
    end

    assign o_result.out_x    = w_x;
    assign o_result.out_y    = w_y;
    assign o_result.out_z    = w_z;
    assign o_result.out_last = i_vertex.last_vertex;

endmodule

### src/vertex_affine_transform.sv
// Top level of the vertex affine transform: configuration registers, input
// and output pipeline registers. Depends on vat_pkg, vat_trig and vat_xform.
//
// Usage:
//   Vertices enter on the i_in_valid / o_in_ready channel as t_vertex and
//   leave on o_out_valid / i_out_ready as t_result, one result transaction
//   per input transaction, in order. A transaction completes on a clock edge
//   where valid and ready are both high.
//   Configuration is written through i_cfg_wr_en, i_cfg_index, i_cfg_data:
//   index 0 operation, 1 axis select, 2 amount; other indexes are ignored.
//   Write it only while no transaction is in flight.
//   The vertex is registered on input, transformed in one pass of logic, and
//   registered on output. Throughput is one vertex per cycle while the sine
//   and cosine cache is ready and the receiver does not stall; the four
//   shared 32x32 multipliers set the critical path. After reset and after
//   every configuration write, the sine and cosine unit recomputes its cache
//   through load, quotient estimate, remainder, fold, radian conversion and
//   the CORDIC steps. o_in_ready stays low meanwhile.
//   When the receiver stalls, the result holds in the output register and
//   one more vertex waits in the input register; o_in_ready then drops.
module vertex_affine_transform #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [vat_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vat_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  vat_pkg::t_vertex                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output vat_pkg::t_result                    o_out_data
);

    logic [1:0]                         r_operation;
    logic [1:0]                         r_axis_select;
    logic signed [vat_pkg::COORD_W-1:0] r_amount;
    logic                               r_s1_valid;
    vat_pkg::t_vertex                   r_s1_vertex;
    logic                               r_out_valid;
    vat_pkg::t_result                   r_out_data;

    logic                               w_cfg_hit;
    logic                               w_s2_load;
    logic                               w_in_take;
    vat_pkg::t_trig                     w_trig;
    vat_pkg::t_result                   w_result;

    // Any write to a register in the list restarts the sine and cosine cache.
    assign w_cfg_hit = i_cfg_wr_en && ((i_cfg_index == vat_pkg::CFG_OPERATION) ||
                                       (i_cfg_index == vat_pkg::CFG_AXIS_SELECT) ||
                                       (i_cfg_index == vat_pkg::CFG_AMOUNT));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation   <= vat_pkg::OP_TRANSLATE;
            r_axis_select <= vat_pkg::AXIS_X;
            r_amount      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                vat_pkg::CFG_OPERATION:   r_operation   <= i_cfg_data[1:0];
                vat_pkg::CFG_AXIS_SELECT: r_axis_select <= i_cfg_data[1:0];
                vat_pkg::CFG_AMOUNT:      r_amount      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vat_trig #(
        .FRACTION_BITS (FRACTION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_hit),
        .i_amount (r_amount),
        .o_trig   (w_trig)
    );

    // Pipeline flow: the output register loads when it is empty or drained.
    assign w_s2_load  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = w_trig.ready && (!r_s1_valid || w_s2_load);
    assign w_in_take  = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_vertex <= i_in_data;
        end
    end

    vat_xform #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_xform (
        .i_vertex      (r_s1_vertex),
        .i_operation   (r_operation),
        .i_axis_select (r_axis_select),
        .i_amount      (r_amount),
        .i_trig        (w_trig),
        .o_result      (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A configuration write invalidates the cached sine and cosine.
    a_cfg_clears_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> !w_trig.ready)
        else $error("trig cache still ready after a configuration write");

    // A vertex in the input register is never dropped while the output stalls.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_load) |=> r_s1_valid)
        else $error("input register lost a vertex during a stall");

    // An accepted transaction always lands in the input register.
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_s1_valid)
        else $error("accepted vertex did not reach the input register");

endmodule
